>>> rtl/core/fcu_pkg.sv
`default_nettype none

package fcu_pkg;

    localparam int MAX_TAPS   = 16;
    localparam int DATA_W     = 16;
    localparam int IDX_W      = 4;
    localparam int TAPCNT_W   = 5;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int GRP_SIZE   = 4;
    localparam int NUM_GRP    = (MAX_TAPS + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = TAPCNT_W'(16);

    // register index, taken from paddr[2]
    localparam logic REG_TAP_COUNT = 1'b0;

    typedef enum logic
    {
        KIND_LOAD   = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t                    kind;
        logic [IDX_W-1:0]         coef_index;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } req_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] result;
        logic                     last_res;
    } rsp_t;

    typedef struct packed
    {
        logic shift;
        logic clear;
        logic capture;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/fcu_cell.sv
`default_nettype none

module fcu_cell
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire fcu_pkg::cell_ctrl_t          ctrl,
    input  wire                               tap_on,
    input  wire                               coef_we,
    input  wire logic signed [fcu_pkg::DATA_W-1:0] coef_value,
    input  wire logic signed [fcu_pkg::DATA_W-1:0] sample_in,
    output logic signed [fcu_pkg::DATA_W-1:0]  sample_out,
    output logic [fcu_pkg::DATA_W-1:0]         prod
);
    import fcu_pkg::*;

    logic signed [DATA_W-1:0]   sample_reg;
    logic signed [DATA_W-1:0]   coef_reg;
    logic [DATA_W-1:0]          prod_reg;
    logic signed [2*DATA_W-1:0] mul_full;
    logic [DATA_W-1:0]          prod_next;

    always_comb
    begin
        mul_full  = coef_reg * sample_reg;
        prod_next = tap_on ? mul_full[DATA_W-1:0] : '0;
    end

    // delay line tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            sample_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sample_reg <= sample_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_reg <= coef_value;
        end
        if (ctrl.capture)
        begin
            prod_reg <= prod_next;
        end
    end

    assign sample_out = sample_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

>>> rtl/core/fcu_sum.sv
`default_nettype none

module fcu_sum
(
    input  wire                                                 clk,
    input  wire                                                 en,
    input  wire logic [fcu_pkg::MAX_TAPS-1:0][fcu_pkg::DATA_W-1:0] prod,
    output logic [fcu_pkg::DATA_W-1:0]                          total
);
    import fcu_pkg::*;

    logic [NUM_GRP-1:0][DATA_W-1:0] grp_reg;
    logic [NUM_GRP-1:0][DATA_W-1:0] grp_next;

    // first level: groups of four products
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < MAX_TAPS)
                begin
                    grp_next[g] = grp_next[g] + prod[g * GRP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg <= grp_next;
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            total = total + grp_reg[g];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/full_linear_convolution_unit.sv
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------
// req       | in        | req_valid, req_stall | req   (kind, coef_index, value, last)
// rsp       | out       | rsp_valid, rsp_stall | rsp   (result, last_res)
// apb       | in        | psel, penable, pready| paddr, pwdata, prdata (tap_count)
//
// an accepted sample passes the delay line shift, the per-tap multiply, the group
// adds and the final add into the output register; a new step issues only once
// the previous step has left the pipeline, and a sample marked last then runs
// taps_use-1 tail steps, taps_use being tap_count clamped to 1..MAX_TAPS,
// req_stall staying high meanwhile; a coefficient load is written when accepted;
// rst_n clears the delay line and control, coefficients stay undefined until loaded
// a stalled rsp holds the result in the final add stage until the output frees

module full_linear_convolution_unit
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               req_valid,
    output logic                              req_stall,
    input  wire fcu_pkg::req_t                req,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output fcu_pkg::rsp_t                     rsp,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire logic [fcu_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fcu_pkg::APB_DW-1:0]   pwdata,
    output logic [fcu_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import fcu_pkg::*;

    logic [TAPCNT_W-1:0] tap_count_reg;
    logic [TAPCNT_W-1:0] taps_use;
    logic [TAPCNT_W-1:0] tail_cnt_reg;
    logic [TAPCNT_W-1:0] tail_cnt_next;
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                s3_valid_next;
    logic                s1_last_reg, s2_last_reg, s3_last_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;

    logic                busy;
    logic                slot_free;
    logic                req_acc;
    logic                sample_issue;
    logic                tail_issue;
    logic                issue;
    logic                step_last;
    logic                coef_load;
    logic signed [DATA_W-1:0] shift_value;
    cell_ctrl_t          ctrl;

    logic signed [MAX_TAPS:0][DATA_W-1:0] chain;
    logic [MAX_TAPS-1:0][DATA_W-1:0]      prod;
    logic [DATA_W-1:0]                    total;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT))
        begin
            tap_count_reg <= pwdata[TAPCNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAP_COUNT)
                    ? {{(APB_DW-TAPCNT_W){1'b0}}, tap_count_reg} : '0;

    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            taps_use = TAPCNT_W'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            taps_use = TAPCNT_W'(MAX_TAPS);
        end
        else
        begin
            taps_use = tap_count_reg;
        end
    end

    // step control
    always_comb
    begin
        busy         = s1_valid_reg || s2_valid_reg || s3_valid_reg;
        slot_free    = !rsp_valid_reg || !rsp_stall;
        req_stall    = busy || (tail_cnt_reg != '0);
        req_acc      = req_valid && !req_stall;
        sample_issue = req_acc && (req.kind == KIND_SAMPLE);
        coef_load    = req_acc && (req.kind == KIND_LOAD);
        tail_issue   = !busy && (tail_cnt_reg != '0);
        issue        = sample_issue || tail_issue;
        shift_value  = tail_issue ? '0 : req.value;
        step_last    = sample_issue ? (req.last && (taps_use == TAPCNT_W'(1)))
                                    : (tail_cnt_reg == TAPCNT_W'(1));

        tail_cnt_next = tail_cnt_reg;
        if (sample_issue && req.last)
        begin
            tail_cnt_next = taps_use - TAPCNT_W'(1);
        end
        else if (tail_issue)
        begin
            tail_cnt_next = tail_cnt_reg - TAPCNT_W'(1);
        end

        s3_valid_next = s2_valid_reg || (s3_valid_reg && !slot_free);

        rsp_valid_next = rsp_valid_reg;
        if (s3_valid_reg && slot_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        ctrl.shift   = issue;
        ctrl.clear   = s1_valid_reg && s1_last_reg;
        ctrl.capture = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_cnt_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            tail_cnt_reg  <= tail_cnt_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s3_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_last_reg <= step_last;
        end
        if (s1_valid_reg)
        begin
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg)
        begin
            s3_last_reg <= s2_last_reg;
        end
        if (s3_valid_reg && slot_free)
        begin
            rsp_reg.result   <= total;
            rsp_reg.last_res <= s3_last_reg;
        end
    end

    // tap chain, newest sample in cell 0
    assign chain[0] = shift_value;

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        fcu_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .tap_on     (32'(taps_use) > k),
            .coef_we    (coef_load && (32'(req.coef_index) == k)),
            .coef_value (req.value),
            .sample_in  (chain[k]),
            .sample_out (chain[k+1]),
            .prod       (prod[k])
        );
    end

    fcu_sum u_sum
    (
        .clk   (clk),
        .en    (s2_valid_reg),
        .prod  (prod),
        .total (total)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
